>>> hw/rtl/ssmm_pkg.sv
// Types, constants and helper functions for the soft-switch memory mapper.
// Used by soft_switch_memory_mapper; depends on nothing else.
package ssmm_pkg;

    // Soft-switch bit positions in the switch word
    localparam int unsigned SW_PREWRITE  = 0;
    localparam int unsigned SW_NOWRITE   = 1;
    localparam int unsigned SW_BANK1     = 2;
    localparam int unsigned SW_READBSR   = 3;
    localparam int unsigned SW_RAMRD     = 8;
    localparam int unsigned SW_RAMWRT    = 9;
    localparam int unsigned SW_INTCXROM  = 10;
    localparam int unsigned SW_ALTZP     = 11;
    localparam int unsigned SW_INTC8ROM  = 12;
    localparam int unsigned SW_SLOTC3ROM = 13;
    localparam int unsigned SW_80STORE   = 14;
    localparam int unsigned SW_TEXT      = 16;
    localparam int unsigned SW_PAGE2     = 18;
    localparam int unsigned SW_HIRES     = 19;

    localparam int unsigned SW_WIDTH = 22;
    localparam logic [SW_WIDTH-1:0] SW_RESET = 22'h01_0000;

    // Configuration register indexes
    localparam logic [2:0] CFG_RAM_LIMIT     = 3'd0;
    localparam logic [2:0] CFG_LANG_CARD     = 3'd1;
    localparam logic [2:0] CFG_ROM_PRESENT   = 3'd2;
    localparam logic [2:0] CFG_ENHANCED      = 3'd3;
    localparam logic [2:0] CFG_ROM_SIZE      = 3'd4;

    // Auxiliary memory is present only above this many bytes
    localparam logic [17:0] AUX_LIMIT = 18'h1_0000;

    // Where an access lands
    typedef enum logic [2:0] {
        TGT_RAM     = 3'd0,
        TGT_ROM     = 3'd1,
        TGT_STATUS  = 3'd2,
        TGT_PER_ROM = 3'd3,
        TGT_PER_IO  = 3'd4,
        TGT_ZERO    = 3'd5,
        TGT_NONE    = 3'd6
    } target_t;

    // Region class of the plain memory map
    typedef enum logic [1:0] {
        MAP_RAM  = 2'd0,
        MAP_ROM  = 2'd1,
        MAP_SLOT = 2'd2
    } map_kind_t;

    // Switch read back by each status address in the 0xC01x page
    function automatic logic [4:0] status_pos(input logic [3:0] idx);
        logic [4:0] pos;
        case (idx)
            4'd1:    pos = 5'd2;
            4'd2:    pos = 5'd3;
            4'd3:    pos = 5'd8;
            4'd4:    pos = 5'd9;
            4'd5:    pos = 5'd10;
            4'd6:    pos = 5'd11;
            4'd7:    pos = 5'd13;
            4'd8:    pos = 5'd14;
            4'd9:    pos = 5'd15;
            4'd10:   pos = 5'd16;
            4'd11:   pos = 5'd17;
            4'd12:   pos = 5'd18;
            4'd13:   pos = 5'd19;
            4'd14:   pos = 5'd20;
            4'd15:   pos = 5'd21;
            default: pos = 5'd0;
        endcase
        return pos;
    endfunction

    // Switch set or cleared by each write pair in the 0xC00x page
    function automatic logic [4:0] extra_pos(input logic [2:0] idx);
        logic [4:0] pos;
        case (idx)
            3'd0:    pos = 5'd14;
            3'd1:    pos = 5'd8;
            3'd2:    pos = 5'd9;
            3'd3:    pos = 5'd10;
            3'd4:    pos = 5'd11;
            3'd5:    pos = 5'd13;
            3'd6:    pos = 5'd21;
            default: pos = 5'd20;
        endcase
        return pos;
    endfunction

    // Language card switch update for an access to 0xC08x
    function automatic logic [SW_WIDTH-1:0] lc_touch(input logic [SW_WIDTH-1:0] sw_in,
                                                     input logic [15:0] addr,
                                                     input logic wr);
        logic [SW_WIDTH-1:0] sw;
        sw = sw_in;
        if (wr)
        begin
            sw[SW_PREWRITE] = 1'b0;
        end
        if (!addr[0])
        begin
            sw[SW_PREWRITE] = 1'b0;
            sw[SW_NOWRITE]  = 1'b1;
        end
        else
        begin
            if (sw[SW_PREWRITE])
            begin
                sw[SW_NOWRITE] = 1'b0;
            end
            if (!wr)
            begin
                sw[SW_PREWRITE] = 1'b1;
            end
        end
        sw[SW_BANK1]   = addr[3];
        sw[SW_READBSR] = (addr[1] == addr[0]);
        return sw;
    endfunction

    // Auxiliary bank selection for a RAM access
    function automatic logic is_aux(input logic [SW_WIDTH-1:0] sw,
                                    input logic [15:0] addr,
                                    input logic wr,
                                    input logic aux_absent);
        logic aux;
        aux = sw[SW_ALTZP] && (addr < 16'h0200 || addr > 16'hC000);
        if (sw[SW_80STORE] && ((addr >= 16'h0400 && addr < 16'h0800)
                               || (sw[SW_HIRES] && addr >= 16'h2000 && addr < 16'h4000)))
        begin
            aux = aux || sw[SW_PAGE2];
        end
        else
        begin
            aux = aux || (addr >= 16'h0200 && addr < 16'hC000
                          && (wr ? sw[SW_RAMWRT] : sw[SW_RAMRD]));
        end
        if (!wr && aux_absent)
        begin
            aux = 1'b0;
        end
        return aux;
    endfunction

endpackage

>>> hw/rtl/soft_switch_memory_mapper.sv
// Soft-switch memory mapper: decodes one processor bus access per request.
// Depends on ssmm_pkg (types, switch positions, lookup functions).
//
// Usage:
//   The slave stream (s_*) takes one bus access per request: the access kind
//   in s_tuser (0 read, 1 write), address and write byte in s_tdata. The
//   master stream (m_*) returns one decoded result per access: the target in
//   m_tuser and offsets, write controls, status byte and switch word in
//   m_tdata. The cfg_* channel writes the configuration registers; it is
//   always ready and must only be used while no access is in flight.
//   An accepted access is registered and shown on m_* right after the edge
//   that accepts it. Throughput is one access per cycle while the receiver
//   keeps m_tready high; the soft-switch word updates in the same cycle as
//   the decode, so accesses follow back to back with no bubble. The result
//   register is the only stage, so when the receiver stalls with a result
//   pending, s_tready drops until that result is taken; it returns the same
//   cycle the pending result leaves. Reset clears the result valid, sets the
//   switch word to text mode only and loads the configuration defaults (128K
//   RAM, language card, ROM, extended switches, 16K ROM).
module soft_switch_memory_mapper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_tuser,   // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [16:0] mem_offset, [17] aux_bank, [18] write_enable,
                                   // [26:19] write_value, [34:27] status_byte,
                                   // [56:35] switch_word, [57] switch_changed, rest zero
    output logic [2:0]  m_tuser,   // [2:0] target

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    // Configuration registers
    logic [17:0] ram_limit_reg;
    logic        lang_card_reg;
    logic        rom_present_reg;
    logic        enhanced_reg;
    logic [14:0] rom_size_reg;

    // Soft-switch state
    logic [ssmm_pkg::SW_WIDTH-1:0] switch_reg;
    logic [ssmm_pkg::SW_WIDTH-1:0] switch_next;

    // Result register
    logic                          out_valid_reg;
    ssmm_pkg::target_t             target_reg;
    logic [16:0]                   offset_reg;
    logic                          aux_reg;
    logic                          we_reg;
    logic [7:0]                    wvalue_reg;
    logic [7:0]                    status_reg;
    logic [ssmm_pkg::SW_WIDTH-1:0] sw_out_reg;
    logic                          changed_reg;

    // Decode results for the access on the slave side
    ssmm_pkg::target_t target_next;
    logic [16:0]       offset_next;
    logic              aux_next;
    logic              we_next;
    logic [7:0]        wvalue_next;
    logic [7:0]        status_next;

    logic        in_fire;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        aux_absent;
    logic [16:0] rom_idx;

    assign wr    = s_tuser;
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign aux_absent = (ram_limit_reg <= ssmm_pkg::AUX_LIMIT);
    // ROM index wraps modulo 2^17; subtracting 0x10000 equals adding it there
    assign rom_idx = ({1'b0, addr} + {2'b00, rom_size_reg}) + 17'h1_0000;

    // Switch update and target decode for one access
    always_comb
    begin
        logic                  lc_page;
        logic                  io_page;
        logic                  io_hit;
        logic [4:0]            pos;
        logic                  bit_val;
        ssmm_pkg::map_kind_t   m_kind;
        logic [16:0]           m_off;
        logic                  m_aux;

        switch_next = switch_reg;
        target_next = ssmm_pkg::TGT_NONE;
        offset_next = '0;
        aux_next    = 1'b0;
        we_next     = 1'b0;
        wvalue_next = '0;
        status_next = '0;
        io_hit      = 1'b0;
        pos         = '0;
        bit_val     = 1'b0;

        lc_page = (addr[15:4] == 12'hC08);
        io_page = (addr[15:8] == 8'hC0);

        // Language card switches
        if (lc_page)
        begin
            switch_next = ssmm_pkg::lc_touch(switch_next, addr, wr);
        end

        // IO page and slot 3 switches: on every read, on writes to the IO page outside 0xC08x
        if (!wr || (io_page && !lc_page))
        begin
            if (enhanced_reg && addr[15:8] == 8'hC3 && !switch_next[ssmm_pkg::SW_SLOTC3ROM])
            begin
                switch_next[ssmm_pkg::SW_INTC8ROM] = 1'b1;
            end
            else if (addr == 16'hCFFF && enhanced_reg)
            begin
                switch_next[ssmm_pkg::SW_INTC8ROM] = 1'b0;
            end
            else if (addr[15:4] == 12'hC05)
            begin
                // Annunciator addresses in the upper half change nothing
                if (!addr[3])
                begin
                    pos = 5'(ssmm_pkg::SW_TEXT) + {3'b000, addr[2:1]};
                    switch_next[pos] = addr[0];
                end
            end
            else if (addr >= 16'hC090 && addr < 16'hC100)
            begin
                io_hit = 1'b1;
            end
            else if (wr && addr[15:4] == 12'hC00 && enhanced_reg)
            begin
                pos = ssmm_pkg::extra_pos(addr[3:1]);
                switch_next[pos] = addr[0];
            end
        end

        // Plain memory map with the updated switches
        m_aux = 1'b0;
        if (addr < 16'hC000)
        begin
            m_kind = ssmm_pkg::MAP_RAM;
            m_off  = {1'b0, addr};
        end
        else if (addr < 16'hD000)
        begin
            m_kind = ssmm_pkg::MAP_SLOT;
            m_off  = {1'b0, addr};
        end
        else if (rom_present_reg
                 && (!lang_card_reg
                     || (wr ? switch_next[ssmm_pkg::SW_NOWRITE]
                            : !switch_next[ssmm_pkg::SW_READBSR])))
        begin
            m_kind = ssmm_pkg::MAP_ROM;
            m_off  = rom_idx;
        end
        else if (lang_card_reg && switch_next[ssmm_pkg::SW_BANK1] && addr < 16'hE000)
        begin
            m_kind = ssmm_pkg::MAP_RAM;
            m_off  = {1'b0, addr - 16'h1000};
        end
        else
        begin
            m_kind = ssmm_pkg::MAP_RAM;
            m_off  = {1'b0, addr};
        end
        if (m_kind == ssmm_pkg::MAP_RAM && ssmm_pkg::is_aux(switch_next, addr, wr, aux_absent))
        begin
            m_aux     = 1'b1;
            m_off[16] = 1'b1;
        end

        if (!wr)
        begin
            // Read priority: IO, internal ROM, status, slot ROM, missing RAM, map
            if (io_hit)
            begin
                target_next = ssmm_pkg::TGT_PER_IO;
                offset_next = {1'b0, addr};
            end
            else if (enhanced_reg && rom_present_reg && addr >= 16'hC100 && addr < 16'hD000
                     && ((!switch_next[ssmm_pkg::SW_SLOTC3ROM] && addr[15:8] == 8'hC3)
                         || (switch_next[ssmm_pkg::SW_INTC8ROM] && addr >= 16'hC800)
                         || switch_next[ssmm_pkg::SW_INTCXROM]))
            begin
                target_next = ssmm_pkg::TGT_ROM;
                offset_next = rom_idx;
            end
            else if (addr[15:4] == 12'hC01 && addr[3:0] != 4'h0)
            begin
                bit_val = switch_next[ssmm_pkg::status_pos(addr[3:0])];
                // The bank-one status reads back inverted
                if (addr[3:0] == 4'h1)
                begin
                    bit_val = !bit_val;
                end
                target_next = ssmm_pkg::TGT_STATUS;
                status_next = {bit_val, 7'b0};
            end
            else if (addr >= 16'hC100 && addr < 16'hC800)
            begin
                target_next = ssmm_pkg::TGT_PER_ROM;
                offset_next = {1'b0, addr};
            end
            else if ({2'b00, addr} >= ram_limit_reg && addr < 16'hC000)
            begin
                target_next = ssmm_pkg::TGT_ZERO;
            end
            else
            begin
                target_next = (m_kind == ssmm_pkg::MAP_ROM) ? ssmm_pkg::TGT_ROM
                                                            : ssmm_pkg::TGT_RAM;
                offset_next = m_off;
                aux_next    = m_aux;
            end
        end
        else
        begin
            // Writes land only in RAM or peripheral IO; everything else drops
            if (lc_page)
            begin
                target_next = ssmm_pkg::TGT_NONE;
            end
            else if (io_page)
            begin
                if (io_hit)
                begin
                    target_next = ssmm_pkg::TGT_PER_IO;
                    offset_next = {1'b0, addr};
                    wvalue_next = wdata;
                end
            end
            else if (m_kind == ssmm_pkg::MAP_RAM && (!m_aux || !aux_absent))
            begin
                target_next = ssmm_pkg::TGT_RAM;
                offset_next = m_off;
                aux_next    = m_aux;
                we_next     = 1'b1;
                wvalue_next = wdata;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_limit_reg   <= 18'h2_0000;
            lang_card_reg   <= 1'b1;
            rom_present_reg <= 1'b1;
            enhanced_reg    <= 1'b1;
            rom_size_reg    <= 15'h4000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssmm_pkg::CFG_RAM_LIMIT:   ram_limit_reg   <= cfg_data;
                ssmm_pkg::CFG_LANG_CARD:   lang_card_reg   <= cfg_data[0];
                ssmm_pkg::CFG_ROM_PRESENT: rom_present_reg <= cfg_data[0];
                ssmm_pkg::CFG_ENHANCED:    enhanced_reg    <= cfg_data[0];
                ssmm_pkg::CFG_ROM_SIZE:    rom_size_reg    <= cfg_data[14:0];
                default:                   ;
            endcase
        end
    end

    // Switch state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_reg    <= ssmm_pkg::SW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                switch_reg    <= switch_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            target_reg  <= target_next;
            offset_reg  <= offset_next;
            aux_reg     <= aux_next;
            we_reg      <= we_next;
            wvalue_reg  <= wvalue_next;
            status_reg  <= status_next;
            sw_out_reg  <= switch_next;
            changed_reg <= (switch_next != switch_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = target_reg;
    assign m_tdata  = {6'b0, changed_reg, sw_out_reg, status_reg, wvalue_reg,
                       we_reg, aux_reg, offset_reg};

    // Switch positions 4 to 7 are never used
    a_unused_switches: assert property (@(posedge clk) disable iff (!rst_n)
        switch_reg[7:4] == 4'b0)
        else $error("unused soft-switch bits set");

    // A RAM store is only requested for the RAM target
    a_we_ram_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && we_reg |-> target_reg == ssmm_pkg::TGT_RAM)
        else $error("write enable outside RAM target");

    // Auxiliary bank always carries offset bit 16
    a_aux_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && aux_reg |-> offset_reg[16])
        else $error("auxiliary access without bank bit");

    // Status reads give only bit 7 and no offset
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && target_reg == ssmm_pkg::TGT_STATUS
        |-> status_reg[6:0] == 7'b0 && offset_reg == 17'b0 && !we_reg)
        else $error("malformed status result");

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted over a stalled result");

    // The reported switch word is the current state
    a_switch_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> sw_out_reg == switch_reg)
        else $error("switch word differs from state");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for soft_switch_memory_mapper: bus accesses in on s_*,
// decoded results checked on m_* against an in-bench model of the switch word.
// Depends on ssmm_pkg and the soft_switch_memory_mapper RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit          ACC_READ       = 1'b0;
    localparam bit          ACC_WRITE      = 1'b1;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned PRINT_LIMIT    = 50;
    localparam int unsigned PHASE_ITEMS    = 320;

    // Switch shown by each status address 0xC011-0xC01F
    localparam int unsigned STATUS_SEL [16] =
        '{0, 2, 3, 8, 9, 10, 11, 13, 14, 15, 16, 17, 18, 19, 20, 21};
    // Switch moved by each write pair 0xC000-0xC00F
    localparam int unsigned EXTRA_SEL [8] = '{14, 8, 9, 10, 11, 13, 21, 20};

    // One decoded access as it leaves the block
    typedef struct {
        ssmm_pkg::target_t tgt;
        logic [16:0]       off;
        logic              aux;
        logic              we;
        logic [7:0]        wv;
        logic [7:0]        sb;
        logic [21:0]       swd;
        logic              chg;
    } decode_t;

    // Keeps the switch word and the settings, predicts each decode and
    // checks the block's results in order.
    class access_scoreboard;
        logic [21:0] sw;
        logic [17:0] ram_limit;
        bit          lc_en;
        bit          rom_en;
        bit          enh;
        logic [14:0] rom_size;
        decode_t     expected_q[$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            sw           = ssmm_pkg::SW_RESET;
            ram_limit    = 18'd131072;
            lc_en        = 1'b1;
            rom_en       = 1'b1;
            enh          = 1'b1;
            rom_size     = 15'd16384;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [2:0] idx, logic [17:0] value);
            case (idx)
                ssmm_pkg::CFG_RAM_LIMIT:   ram_limit = value;
                ssmm_pkg::CFG_LANG_CARD:   lc_en     = value[0];
                ssmm_pkg::CFG_ROM_PRESENT: rom_en    = value[0];
                ssmm_pkg::CFG_ENHANCED:    enh       = value[0];
                ssmm_pkg::CFG_ROM_SIZE:    rom_size  = value[14:0];
                default:                   ;
            endcase
        endfunction

        // Language card switch sequence for an access to 0xC08x
        function void touch_lang_card(logic [15:0] a, bit wr);
            if (wr)
            begin
                sw[ssmm_pkg::SW_PREWRITE] = 1'b0;
            end
            if (!a[0])
            begin
                sw[ssmm_pkg::SW_PREWRITE] = 1'b0;
                sw[ssmm_pkg::SW_NOWRITE]  = 1'b1;
            end
            else
            begin
                if (sw[ssmm_pkg::SW_PREWRITE])
                begin
                    sw[ssmm_pkg::SW_NOWRITE] = 1'b0;
                end
                if (!wr)
                begin
                    sw[ssmm_pkg::SW_PREWRITE] = 1'b1;
                end
            end
            sw[ssmm_pkg::SW_BANK1]   = a[3];
            sw[ssmm_pkg::SW_READBSR] = (a[1] == a[0]);
        endfunction

        // IO page and slot 3 switches; true when the access is peripheral IO
        function bit io_switch_hit(logic [15:0] a, bit wr);
            if (enh && a >= 16'hC300 && a < 16'hC400 && !sw[ssmm_pkg::SW_SLOTC3ROM])
            begin
                sw[ssmm_pkg::SW_INTC8ROM] = 1'b1;
            end
            else if (a == 16'hCFFF && enh)
            begin
                sw[ssmm_pkg::SW_INTC8ROM] = 1'b0;
            end
            else if (a[15:4] == 12'hC05)
            begin
                // Annunciator addresses in the upper half change nothing
                if (!a[3])
                begin
                    sw[ssmm_pkg::SW_TEXT + a[2:1]] = a[0];
                end
            end
            else if (a >= 16'hC090 && a < 16'hC100)
            begin
                return 1'b1;
            end
            else if (wr && a[15:4] == 12'hC00 && enh)
            begin
                sw[EXTRA_SEL[a[3:1]]] = a[0];
            end
            return 1'b0;
        endfunction

        function bit aux_select(logic [15:0] a, bit wr);
            bit sel;
            if (!wr && ram_limit <= 18'h1_0000)
            begin
                return 1'b0;
            end
            sel = sw[ssmm_pkg::SW_ALTZP] && (a < 16'h0200 || a > 16'hC000);
            if (sw[ssmm_pkg::SW_80STORE]
                && ((a >= 16'h0400 && a < 16'h0800)
                    || (sw[ssmm_pkg::SW_HIRES] && a >= 16'h2000 && a < 16'h4000)))
            begin
                sel = sel || sw[ssmm_pkg::SW_PAGE2];
            end
            else
            begin
                sel = sel || (a >= 16'h0200 && a < 16'hC000
                              && (wr ? sw[ssmm_pkg::SW_RAMWRT] : sw[ssmm_pkg::SW_RAMRD]));
            end
            return sel;
        endfunction

        // ROM index; addresses below the ROM start wrap around 2^17
        function logic [16:0] rom_offset(logic [15:0] a);
            logic [31:0] sum;
            sum = 32'(a) + 32'(rom_size) - 32'h1_0000;
            return sum[16:0];
        endfunction

        function ssmm_pkg::map_kind_t map_plain(logic [15:0] a, bit wr,
                                                output logic [16:0] off, output bit aux);
            aux = 1'b0;
            if (a < 16'hC000)
            begin
                off = {1'b0, a};
            end
            else if (a < 16'hD000)
            begin
                off = {1'b0, a};
                return ssmm_pkg::MAP_SLOT;
            end
            else if (rom_en && (!lc_en || (wr ? sw[ssmm_pkg::SW_NOWRITE]
                                              : !sw[ssmm_pkg::SW_READBSR])))
            begin
                off = rom_offset(a);
                return ssmm_pkg::MAP_ROM;
            end
            else if (lc_en && sw[ssmm_pkg::SW_BANK1] && a < 16'hE000)
            begin
                off = {1'b0, a - 16'h1000};
            end
            else
            begin
                off = {1'b0, a};
            end
            if (aux_select(a, wr))
            begin
                aux     = 1'b1;
                off[16] = 1'b1;
            end
            return ssmm_pkg::MAP_RAM;
        endfunction

        function decode_t predict_decode(bit wr, logic [15:0] a, logic [7:0] d);
            decode_t              r;
            logic [21:0]          prior;
            ssmm_pkg::map_kind_t  kind;
            logic [16:0]          off;
            bit                   aux;
            bit                   flag;
            prior = sw;
            r.tgt = ssmm_pkg::TGT_NONE;
            r.off = '0;
            r.aux = 1'b0;
            r.we  = 1'b0;
            r.wv  = '0;
            r.sb  = '0;
            if (!wr)
            begin
                if (a[15:4] == 12'hC08)
                begin
                    touch_lang_card(a, 1'b0);
                end
                if (io_switch_hit(a, 1'b0))
                begin
                    r.tgt = ssmm_pkg::TGT_PER_IO;
                    r.off = {1'b0, a};
                end
                else if (enh && rom_en && a >= 16'hC100 && a < 16'hD000
                         && ((!sw[ssmm_pkg::SW_SLOTC3ROM] && a >= 16'hC300 && a < 16'hC400)
                             || (sw[ssmm_pkg::SW_INTC8ROM] && a >= 16'hC800)
                             || sw[ssmm_pkg::SW_INTCXROM]))
                begin
                    r.tgt = ssmm_pkg::TGT_ROM;
                    r.off = rom_offset(a);
                end
                else if (a[15:4] == 12'hC01 && a[3:0] != 4'd0)
                begin
                    // Bank-one status reads back inverted
                    flag = sw[STATUS_SEL[a[3:0]]];
                    if (a[3:0] == 4'd1)
                    begin
                        flag = !flag;
                    end
                    r.tgt = ssmm_pkg::TGT_STATUS;
                    r.sb  = flag ? 8'h80 : 8'h00;
                end
                else if (a >= 16'hC100 && a < 16'hC800)
                begin
                    r.tgt = ssmm_pkg::TGT_PER_ROM;
                    r.off = {1'b0, a};
                end
                else if (32'(a) >= 32'(ram_limit) && a < 16'hC000)
                begin
                    r.tgt = ssmm_pkg::TGT_ZERO;
                end
                else
                begin
                    // Unanswered IO and expansion reads land on main RAM
                    kind  = map_plain(a, 1'b0, off, aux);
                    r.tgt = (kind == ssmm_pkg::MAP_ROM) ? ssmm_pkg::TGT_ROM
                                                        : ssmm_pkg::TGT_RAM;
                    r.off = off;
                    r.aux = aux;
                end
            end
            else
            begin
                if (a[15:4] == 12'hC08)
                begin
                    touch_lang_card(a, 1'b1);
                end
                else if (a >= 16'hC000 && a < 16'hC100)
                begin
                    if (io_switch_hit(a, 1'b1))
                    begin
                        r.tgt = ssmm_pkg::TGT_PER_IO;
                        r.off = {1'b0, a};
                        r.wv  = d;
                    end
                end
                else
                begin
                    // Slot area and ROM writes are dropped, so are aux writes
                    // without auxiliary memory
                    kind = map_plain(a, 1'b1, off, aux);
                    if (kind == ssmm_pkg::MAP_RAM && (!aux || ram_limit > 18'h1_0000))
                    begin
                        r.tgt = ssmm_pkg::TGT_RAM;
                        r.off = off;
                        r.aux = aux;
                        r.we  = 1'b1;
                        r.wv  = d;
                    end
                end
            end
            r.swd = sw;
            r.chg = (sw != prior);
            return r;
        endfunction

        function void note_access(bit wr, logic [15:0] a, logic [7:0] d);
            expected_q.push_back(predict_decode(wr, a, d));
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
            begin
                $display("MISMATCH result %0d: %s", results_seen, msg);
            end
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(logic [2:0] tuser, logic [63:0] tdata);
            decode_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("no access pending, tuser %0h tdata %0h", tuser, tdata));
                return;
            end
            e = expected_q.pop_front();
            compare_field("target", 32'(tuser), 32'(e.tgt));
            compare_field("mem_offset", 32'(tdata[16:0]), 32'(e.off));
            compare_field("aux_bank", 32'(tdata[17]), 32'(e.aux));
            compare_field("write_enable", 32'(tdata[18]), 32'(e.we));
            compare_field("write_value", 32'(tdata[26:19]), 32'(e.wv));
            compare_field("status_byte", 32'(tdata[34:27]), 32'(e.sb));
            compare_field("switch_word", 32'(tdata[56:35]), 32'(e.swd));
            compare_field("switch_changed", 32'(tdata[57]), 32'(e.chg));
            compare_field("tdata padding", 32'(tdata[63:58]), 32'd0);
            results_seen++;
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [17:0] cfg_data  = '0;

    access_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int unsigned      quiet_cycles = 0;

    soft_switch_memory_mapper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Accepted requests feed the model; accepted results are checked
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_access(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // Ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall bursts, plus one long hold that backs the
    // block up into its input
    initial
    begin
        int unsigned hold;
        bit          long_hold_done;
        hold           = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && sb.results_seen >= 400)
            begin
                long_hold_done = 1'b1;
                hold           = 79;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one access and waits until the block takes the request
    task automatic send_access(bit wr, logic [15:0] a, logic [7:0] d);
        int unsigned gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wr;
        s_tdata  <= {d, a};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Settings change only with no access in flight
    task automatic apply_setting(logic [17:0] ram, bit lc, bit rom, bit ext,
                                 logic [14:0] rsz);
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(ssmm_pkg::CFG_RAM_LIMIT, ram);
        write_reg(ssmm_pkg::CFG_LANG_CARD, 18'(lc));
        write_reg(ssmm_pkg::CFG_ROM_PRESENT, 18'(rom));
        write_reg(ssmm_pkg::CFG_ENHANCED, 18'(ext));
        write_reg(ssmm_pkg::CFG_ROM_SIZE, 18'(rsz));
    endtask

    // Address spread over the regions that decode differently
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 15))
            0, 1:    return 16'hC000 | 16'($urandom_range(0, 255));
            2:       return 16'hC010 | 16'($urandom_range(0, 15));
            3:       return 16'hC080 | 16'($urandom_range(0, 15));
            4:       return 16'hC300 | 16'($urandom_range(0, 255));
            5:       return ($urandom_range(0, 1) == 0) ? 16'hCFFF
                                                        : 16'($urandom_range(16'hC800, 16'hCFFF));
            6:       return 16'($urandom_range(16'hC100, 16'hCFFF));
            7:       return 16'($urandom_range(0, 16'h01FF));
            8:       return 16'($urandom_range(16'h0400, 16'h07FF));
            9:       return 16'($urandom_range(16'h2000, 16'h3FFF));
            10, 11:  return 16'($urandom_range(16'h0200, 16'hBFFF));
            12, 13:  return 16'($urandom_range(16'hD000, 16'hFFFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Random traffic: switch sequences followed by the accesses they steer, and single accesses
    task automatic run_random(int unsigned count);
        int unsigned sent;
        logic [15:0] a;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Double read of a language card switch, then banked traffic
                    a = 16'hC080 | 16'($urandom_range(0, 15));
                    send_access(ACC_READ, a, 8'($urandom));
                    send_access(ACC_READ, a, 8'($urandom));
                    repeat (3)
                    begin
                        send_access(1'($urandom_range(0, 1)),
                                    16'($urandom_range(16'hD000, 16'hFFFF)), 8'($urandom));
                    end
                    sent += 5;
                end
                2, 3:
                begin
                    // Memory or display switch change, then an access it affects
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_access(ACC_WRITE, 16'hC000 | 16'($urandom_range(0, 15)),
                                    8'($urandom));
                    end
                    else
                    begin
                        send_access(1'($urandom_range(0, 1)),
                                    16'hC050 | 16'($urandom_range(0, 15)), 8'($urandom));
                    end
                    send_access(1'($urandom_range(0, 1)), pick_address(), 8'($urandom));
                    send_access(1'($urandom_range(0, 1)), pick_address(), 8'($urandom));
                    sent += 3;
                end
                default:
                begin
                    send_access(1'($urandom_range(0, 1)), pick_address(),
                                8'($urandom_range(0, 255)));
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed accesses at the reset settings
        send_access(ACC_READ,  16'h0000, 8'h00);
        send_access(ACC_WRITE, 16'hFFFF, 8'hFF);
        send_access(ACC_READ,  16'hC000, 8'h00);
        send_access(ACC_READ,  16'hC080, 8'h00);
        send_access(ACC_READ,  16'hC08B, 8'h00);
        send_access(ACC_READ,  16'hC08B, 8'h00);
        send_access(ACC_WRITE, 16'hD000, 8'hA5);
        send_access(ACC_READ,  16'hD000, 8'h00);
        send_access(ACC_WRITE, 16'hC005, 8'h00);
        send_access(ACC_WRITE, 16'hBFFF, 8'h5A);
        send_access(ACC_WRITE, 16'hC009, 8'h00);
        send_access(ACC_READ,  16'h01FF, 8'h00);
        send_access(ACC_WRITE, 16'hC001, 8'h00);
        send_access(ACC_READ,  16'hC055, 8'h00);
        send_access(ACC_READ,  16'hC057, 8'h00);
        send_access(ACC_WRITE, 16'h2000, 8'h3C);
        send_access(ACC_READ,  16'hC05F, 8'h00);
        send_access(ACC_READ,  16'hC011, 8'h00);
        send_access(ACC_READ,  16'hC01F, 8'h00);
        send_access(ACC_READ,  16'hC300, 8'h00);
        send_access(ACC_READ,  16'hC800, 8'h00);
        send_access(ACC_READ,  16'hCFFF, 8'h00);
        send_access(ACC_WRITE, 16'hC100, 8'h11);
        send_access(ACC_WRITE, 16'hC0A0, 8'h77);
        send_access(ACC_READ,  16'hC200, 8'h00);

        run_random(PHASE_ITEMS);

        // No RAM, no language card, smallest ROM
        apply_setting(18'd0, 1'b0, 1'b1, 1'b1, 15'd12288);
        run_random(PHASE_ITEMS);

        // Exactly 64K, no ROM, plain machine
        apply_setting(18'h1_0000, 1'b1, 1'b0, 1'b0, 15'd16384);
        run_random(PHASE_ITEMS);

        // Just over 64K, ROM size anywhere in range
        apply_setting(18'h1_0001, 1'b1, 1'b1, 1'b0,
                      15'($urandom_range(12288, 16384)));
        run_random(PHASE_ITEMS);

        // 32K leaves a hole of zero bytes below the IO page
        apply_setting(18'h0_8000, 1'b0, 1'b0, 1'b1, 15'd12288);
        run_random(PHASE_ITEMS);

        // Full machine again, back to back with no stalls
        apply_setting(18'd131072, 1'b1, 1'b1, 1'b1, 15'd16384);
        idle_on = 1'b0;
        run_random(PHASE_ITEMS);

        stop_sending();
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
